[rtl/ttchs_pkg.sv]
package ttchs_pkg;

  localparam logic [1:0] CMD_SEARCH = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] ST_PRESENT = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [31:0] SEED_A = 32'd61;
  localparam logic [31:0] MUL_A  = 32'h27d4eb2d;
  localparam logic [31:0] MUL_B  = 32'h045d9f3b;

  typedef struct packed {
    logic        vld;
    logic [31:0] key;
    logic [31:0] data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clr;
    logic accept;
    logic look_rd;
    logic look;
    logic walk_chk;
    logic walk_idx;
    logic sh_rdp;
    logic sh_rdt;
    logic sh_hs;
    logic sh_wr;
    logic res_full;
    logic fin;
    logic out_load;
  } ttchs_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic need_walk;
    logic slot_free;
    logic path_end;
    logic dep_zero;
    logic dep_one;
    logic clr_end;
  } ttchs_sts_t;

endpackage

[rtl/ttchs_if.sv]
interface ttchs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] key;
  logic signed [31:0] value;
  modport source (output valid, cmd, key, value, input ready);
  modport sink (input valid, cmd, key, value, output ready);
endinterface

interface ttchs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  modport source (output valid, status, read_value, input ready);
  modport sink (input valid, status, read_value, output ready);
endinterface

[rtl/ttchs_ram.sv]
module ttchs_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ttchs_hash.sv]
module ttchs_hash import ttchs_pkg::*; #(
  parameter int SLOTS = 512,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [31:0]      key,
  output logic             done,
  output logic [IDX_W-1:0] ha,
  output logic [IDX_W-1:0] hb
);

  localparam bit POW2 = (SLOTS > 1) && ((SLOTS & (SLOTS - 1)) == 0);

  logic        v1_r, v2_r, v3_r;
  logic [31:0] pa_r, pb_r, ma_r, mb_r, fa_r, mb2_r, fb;

  function automatic logic [31:0] pre_a(input logic [31:0] k);
    logic [31:0] v;
    v = (k ^ SEED_A) ^ (k >> 16);
    v = v + (v << 3);
    v = v ^ (v >> 4);
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pa_r <= pre_a(key);
      pb_r <= key ^ (key >> 16);
    end
    if (v1_r) begin
      ma_r <= pa_r * MUL_A;
      mb_r <= pb_r * MUL_B;
    end
    if (v2_r) begin
      fa_r  <= ma_r ^ (ma_r >> 15);
      mb2_r <= (mb_r ^ (mb_r >> 16)) * MUL_B;
    end
  end

  assign fb = mb2_r ^ (mb2_r >> 16);

  generate
    if (POW2) begin : g_mask
      logic             v4_r;
      logic [IDX_W-1:0] ha_r, hb_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v4_r <= 1'b0;
        end else begin
          v4_r <= v3_r;
        end
      end

      always_ff @(posedge clk) begin
        if (v3_r) begin
          ha_r <= fa_r[IDX_W-1:0];
          hb_r <= fb[IDX_W-1:0];
        end
      end

      assign done = v4_r;
      assign ha   = ha_r;
      assign hb   = hb_r;
    end else begin : g_mod
      localparam int STEPS = 8;
      localparam logic [IDX_W:0] SLOTS_V = (IDX_W + 1)'(SLOTS);

      logic             busy_r, done_r;
      logic [2:0]       cnt_r;
      logic [31:0]      sa_r, sb_r;
      logic [IDX_W-1:0] ra_r, rb_r;

      function automatic logic [IDX_W-1:0] mod4(input logic [IDX_W-1:0] r,
                                                input logic [3:0] nib);
        logic [IDX_W:0]   t;
        logic [IDX_W-1:0] acc;
        acc = r;
        for (int j = 3; j >= 0; j--) begin
          t = {acc, nib[j]};
          if (t >= SLOTS_V) begin
            t = t - SLOTS_V;
          end
          acc = t[IDX_W-1:0];
        end
        return acc;
      endfunction

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          done_r <= 1'b0;
          if (v3_r) begin
            busy_r <= 1'b1;
            cnt_r  <= '0;
          end else if (busy_r) begin
            cnt_r <= cnt_r + 3'd1;
            if (cnt_r == 3'(STEPS - 1)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (v3_r) begin
          sa_r <= fa_r;
          sb_r <= fb;
          ra_r <= '0;
          rb_r <= '0;
        end else if (busy_r) begin
          ra_r <= mod4(ra_r, sa_r[31:28]);
          rb_r <= mod4(rb_r, sb_r[31:28]);
          sa_r <= sa_r << 4;
          sb_r <= sb_r << 4;
        end
      end

      assign done = done_r;
      assign ha   = ra_r;
      assign hb   = rb_r;
    end
  endgenerate

endmodule

[rtl/ttchs_dp.sv]
module ttchs_dp import ttchs_pkg::*; #(
  parameter int SLOTS    = 512,
  parameter int MAX_PATH = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ttchs_cmd_t  cmd,
  output ttchs_sts_t  sts,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_value
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PA_W  = (MAX_PATH > 1) ? $clog2(MAX_PATH) : 1;
  localparam int DEP_W = $clog2(MAX_PATH + 1);

  entry_t           a_rd, b_rd, a_wd, b_wd, cur, new_ent;
  logic             a_we, b_we;
  logic [IDX_W-1:0] a_wa, b_wa, a_ra, b_ra;
  logic             p_we;
  logic [PA_W-1:0]  p_wa, p_ra;
  logic [IDX_W-1:0] p_rd;
  logic             h_start, h_done;
  logic [31:0]      h_key;
  logic [IDX_W-1:0] h_a, h_b;
  logic             ma, mb;
  logic [1:0]       look_st;
  logic [31:0]      look_rv;
  logic [DEP_W-1:0] dm1;

  logic [1:0]       cmd_r;
  logic [31:0]      key_r, val_r;
  logic [IDX_W-1:0] ha_r, hb_r, idx_r, src_r, cnt_r;
  logic             t_r;
  logic [DEP_W-1:0] depth_r;
  entry_t           ent_r;
  logic [1:0]       res_st_r, out_st_r;
  logic [31:0]      res_rv_r, out_rv_r;

  ttchs_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_tab_a (
    .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd)
  );

  ttchs_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_tab_b (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd)
  );

  ttchs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PATH)) u_path (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(idx_r), .raddr(p_ra), .rdata(p_rd)
  );

  ttchs_hash #(.SLOTS(SLOTS)) u_hash (
    .clk(clk), .rst_n(rst_n), .start(h_start), .key(h_key),
    .done(h_done), .ha(h_a), .hb(h_b)
  );

  assign new_ent = '{vld: 1'b1, key: key_r, data: val_r};
  assign cur     = t_r ? b_rd : a_rd;
  assign ma      = a_rd.vld && (a_rd.key == key_r);
  assign mb      = b_rd.vld && (b_rd.key == key_r);
  assign dm1     = depth_r - DEP_W'(1);

  assign a_ra = cmd.look_rd ? h_a : (cmd.sh_rdt ? p_rd : idx_r);
  assign b_ra = cmd.look_rd ? h_b : (cmd.sh_rdt ? p_rd : idx_r);

  assign p_we = cmd.walk_chk && cur.vld;
  assign p_wa = depth_r[PA_W-1:0];
  assign p_ra = dm1[PA_W-1:0];

  assign h_start = cmd.accept || (cmd.walk_chk && cur.vld && !sts.path_end) || cmd.sh_hs;
  assign h_key   = cmd.accept ? in_key : cur.key;

  always_comb begin
    a_we = 1'b0;
    a_wa = ha_r;
    a_wd = new_ent;
    b_we = 1'b0;
    b_wa = hb_r;
    b_wd = new_ent;
    if (cmd.clr) begin
      a_we = 1'b1;
      a_wa = cnt_r;
      a_wd = '0;
      b_we = 1'b1;
      b_wa = cnt_r;
      b_wd = '0;
    end
    if (cmd.look) begin
      case (cmd_r)
        CMD_INSERT: begin
          if (ma) begin
            a_we = 1'b1;
          end else if (mb) begin
            b_we = 1'b1;
          end else if (!a_rd.vld) begin
            a_we = 1'b1;
          end else if (!b_rd.vld) begin
            b_we = 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (ma) begin
            a_we = 1'b1;
            a_wd = '0;
          end else if (mb) begin
            b_we = 1'b1;
            b_wd = '0;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.sh_wr) begin
      if (t_r) begin
        b_we = 1'b1;
        b_wa = src_r;
        b_wd = '0;
        a_we = 1'b1;
        a_wa = h_a;
        a_wd = ent_r;
      end else begin
        a_we = 1'b1;
        a_wa = src_r;
        a_wd = '0;
        b_we = 1'b1;
        b_wa = h_b;
        b_wd = ent_r;
      end
    end
    if (cmd.fin) begin
      a_we = 1'b1;
    end
  end

  always_comb begin
    look_st = ST_ABSENT;
    look_rv = '0;
    if ((cmd_r inside {CMD_SEARCH, CMD_INSERT, CMD_REMOVE}) && (ma || mb)) begin
      look_st = ST_PRESENT;
    end
    if (cmd_r == CMD_SEARCH) begin
      if (ma) begin
        look_rv = a_rd.data;
      end else if (mb) begin
        look_rv = b_rd.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.clr) begin
      cnt_r <= cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
      val_r <= in_value;
    end
    if (cmd.look_rd) begin
      ha_r <= h_a;
      hb_r <= h_b;
    end
    if (cmd.look) begin
      res_st_r <= look_st;
      res_rv_r <= look_rv;
      t_r      <= 1'b0;
      idx_r    <= ha_r;
      depth_r  <= '0;
    end
    if (cmd.walk_chk && cur.vld) begin
      t_r     <= ~t_r;
      depth_r <= depth_r + DEP_W'(1);
    end
    if (cmd.walk_idx) begin
      idx_r <= t_r ? h_b : h_a;
    end
    if (cmd.sh_rdp) begin
      t_r <= ~t_r;
    end
    if (cmd.sh_rdt) begin
      src_r <= p_rd;
    end
    if (cmd.sh_hs) begin
      ent_r <= cur;
    end
    if (cmd.sh_wr) begin
      depth_r <= dm1;
    end
    if (cmd.res_full) begin
      res_st_r <= ST_FULL;
      res_rv_r <= '0;
    end
    if (cmd.fin) begin
      res_st_r <= ST_ABSENT;
      res_rv_r <= '0;
    end
    if (cmd.out_load) begin
      out_st_r <= res_st_r;
      out_rv_r <= res_rv_r;
    end
  end

  assign sts.hash_done = h_done;
  assign sts.need_walk = (cmd_r == CMD_INSERT) && !ma && !mb && a_rd.vld && b_rd.vld;
  assign sts.slot_free = !cur.vld;
  assign sts.path_end  = depth_r == DEP_W'(MAX_PATH - 1);
  assign sts.dep_zero  = depth_r == '0;
  assign sts.dep_one   = depth_r == DEP_W'(1);
  assign sts.clr_end   = cnt_r == IDX_W'(SLOTS - 1);

  assign out_status     = out_st_r;
  assign out_read_value = out_rv_r;

endmodule

[rtl/ttchs_ctrl.sv]
module ttchs_ctrl import ttchs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ttchs_sts_t sts,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output ttchs_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_LOOK, S_W_RD, S_W_CHK, S_W_HASH,
    S_SH_RDP, S_SH_RDT, S_SH_HS, S_SH_WT, S_FIN, S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    out_vld_nxt = out_vld_r && !out_ready;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.hash_done) begin
          cmd.look_rd = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = sts.need_walk ? S_W_RD : S_RESP;
      end
      S_W_RD: begin
        state_nxt = S_W_CHK;
      end
      S_W_CHK: begin
        cmd.walk_chk = 1'b1;
        if (sts.slot_free) begin
          state_nxt = sts.dep_zero ? S_FIN : S_SH_RDP;
        end else if (sts.path_end) begin
          cmd.res_full = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          state_nxt = S_W_HASH;
        end
      end
      S_W_HASH: begin
        if (sts.hash_done) begin
          cmd.walk_idx = 1'b1;
          state_nxt    = S_W_RD;
        end
      end
      S_SH_RDP: begin
        cmd.sh_rdp = 1'b1;
        state_nxt  = S_SH_RDT;
      end
      S_SH_RDT: begin
        cmd.sh_rdt = 1'b1;
        state_nxt  = S_SH_HS;
      end
      S_SH_HS: begin
        cmd.sh_hs = 1'b1;
        state_nxt = S_SH_WT;
      end
      S_SH_WT: begin
        if (sts.hash_done) begin
          cmd.sh_wr = 1'b1;
          state_nxt = sts.dep_one ? S_FIN : S_SH_RDP;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_vld_r || out_ready) begin
          cmd.out_load = 1'b1;
          out_vld_nxt  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_vld_r;

endmodule

[rtl/two_table_cuckoo_hash_store_unit.sv]
// Two-table cuckoo key/value store.
// in_ch carries one command per transaction: cmd (search, insert, remove,
// no-op), a 32-bit key and, for insert, a 32-bit value. out_ch returns one
// transaction per command: status (present, absent or placed, full) and the
// stored value on a search hit, zero otherwise.
// Commands run one at a time. With a power-of-two table size the slot hash
// is a register pipeline; other sizes then reduce it modulo the table size,
// four bits per step. A search, remove or simple insert hashes the key,
// reads both tables and registers its result. An insert that must evict
// walks the path one slot per hop, one hash each, over up to MAX_PATH slots,
// then moves each entry on the path back by one slot, one hash each.
// The hash unit and the single read port of each table set the pace of these steps.
// After reset both tables are swept empty, one slot per cycle, over all
// SLOTS_PER_TABLE slots; in_ch.ready stays low during that sweep.
// A finished result waits in an output register; the next command is
// accepted meanwhile, and its result waits until out_ch.ready takes the one
// ahead of it.
module two_table_cuckoo_hash_store_unit import ttchs_pkg::*; #(
  parameter int SLOTS_PER_TABLE = 512,
  parameter int MAX_PATH        = 50
) (
  input logic         clk,
  input logic         rst_n,
  ttchs_in_if.sink    in_ch,
  ttchs_out_if.source out_ch
);

  ttchs_cmd_t cmd;
  ttchs_sts_t sts;

  ttchs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .sts       (sts),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  ttchs_dp #(.SLOTS(SLOTS_PER_TABLE), .MAX_PATH(MAX_PATH)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_cmd         (in_ch.cmd),
    .in_key         (in_ch.key),
    .in_value       (in_ch.value),
    .out_status     (out_ch.status),
    .out_read_value (out_ch.read_value)
  );

endmodule

[dv/ttchs_store_scoreboard.sv]
class ttchs_store_scoreboard;
  localparam int SLOTS = 512;
  localparam int PATH_MAX = 50;

  logic        vld_a[SLOTS];
  logic [31:0] key_a[SLOTS];
  logic [31:0] dat_a[SLOTS];
  logic        vld_b[SLOTS];
  logic [31:0] key_b[SLOTS];
  logic [31:0] dat_b[SLOTS];
  logic [1:0]  status_q[$];
  logic [31:0] value_q[$];
  int          errors;
  int          full_seen;

  function new();
    for (int i = 0; i < SLOTS; i++) begin
      vld_a[i] = 1'b0;
      vld_b[i] = 1'b0;
      key_a[i] = '0;
      key_b[i] = '0;
      dat_a[i] = '0;
      dat_b[i] = '0;
    end
    errors = 0;
    full_seen = 0;
  endfunction

  function automatic int home_a(logic [31:0] k);
    logic [31:0] v;
    v = k;
    v = (v ^ 32'd61) ^ (v >> 16);
    v = v + (v << 3);
    v = v ^ (v >> 4);
    v = v * 32'h27d4eb2d;
    v = v ^ (v >> 15);
    return int'(v % SLOTS);
  endfunction

  function automatic int home_b(logic [31:0] k);
    logic [31:0] v;
    v = k;
    v = ((v >> 16) ^ v) * 32'h045d9f3b;
    v = ((v >> 16) ^ v) * 32'h045d9f3b;
    v = (v >> 16) ^ v;
    return int'(v % SLOTS);
  endfunction

  function automatic bit evict_walk(int start);
    int tbl;
    int idx;
    int depth;
    int trail[PATH_MAX];
    bit found;
    int src;
    int dst;
    logic [31:0] k;
    logic [31:0] d;
    tbl = 0;
    idx = start;
    found = 0;
    for (depth = 0; depth < PATH_MAX; depth++) begin
      if (!(tbl == 0 ? vld_a[idx] : vld_b[idx])) begin
        found = 1;
        break;
      end
      trail[depth] = idx;
      k = tbl == 0 ? key_a[idx] : key_b[idx];
      tbl = 1 - tbl;
      idx = tbl == 0 ? home_a(k) : home_b(k);
    end
    if (!found) return 0;
    for (int i = depth; i > 0; i--) begin
      tbl = 1 - tbl;
      src = trail[i-1];
      if (tbl == 0) begin
        k = key_a[src];
        d = dat_a[src];
        dst = home_b(k);
        vld_b[dst] = 1'b1;
        key_b[dst] = k;
        dat_b[dst] = d;
        vld_a[src] = 1'b0;
      end else begin
        k = key_b[src];
        d = dat_b[src];
        dst = home_a(k);
        vld_a[dst] = 1'b1;
        key_a[dst] = k;
        dat_a[dst] = d;
        vld_b[src] = 1'b0;
      end
    end
    return 1;
  endfunction

  function void note_command(logic [1:0] cmd, logic [31:0] k, logic [31:0] v);
    int ha;
    int hb;
    bit hit_a;
    bit hit_b;
    logic [1:0] st;
    logic [31:0] rv;
    ha = home_a(k);
    hb = home_b(k);
    hit_a = vld_a[ha] && key_a[ha] == k;
    hit_b = vld_b[hb] && key_b[hb] == k;
    st = ttchs_pkg::ST_ABSENT;
    rv = '0;
    case (cmd)
      ttchs_pkg::CMD_SEARCH: begin
        if (hit_a) begin
          st = ttchs_pkg::ST_PRESENT;
          rv = dat_a[ha];
        end else if (hit_b) begin
          st = ttchs_pkg::ST_PRESENT;
          rv = dat_b[hb];
        end
      end
      ttchs_pkg::CMD_INSERT: begin
        if (hit_a) begin
          dat_a[ha] = v;
          st = ttchs_pkg::ST_PRESENT;
        end else if (hit_b) begin
          dat_b[hb] = v;
          st = ttchs_pkg::ST_PRESENT;
        end else if (!vld_a[ha]) begin
          vld_a[ha] = 1'b1;
          key_a[ha] = k;
          dat_a[ha] = v;
        end else if (!vld_b[hb]) begin
          vld_b[hb] = 1'b1;
          key_b[hb] = k;
          dat_b[hb] = v;
        end else if (evict_walk(ha)) begin
          vld_a[ha] = 1'b1;
          key_a[ha] = k;
          dat_a[ha] = v;
        end else begin
          st = ttchs_pkg::ST_FULL;
          full_seen++;
        end
      end
      ttchs_pkg::CMD_REMOVE: begin
        if (hit_a) begin
          vld_a[ha] = 1'b0;
          st = ttchs_pkg::ST_PRESENT;
        end else if (hit_b) begin
          vld_b[hb] = 1'b0;
          st = ttchs_pkg::ST_PRESENT;
        end
      end
      default: ;
    endcase
    status_q = {status_q, st};
    value_q = {value_q, rv};
  endfunction

  function void check_result(logic [1:0] st, logic [31:0] rv);
    if (status_q.size() == 0) begin
      $display("%0t: unexpected result status=%0d value=%h", $time, st, rv);
      errors++;
      return;
    end
    if (st !== status_q[0]) begin
      $display("%0t: status expected %0d actual %0d", $time, status_q[0], st);
      errors++;
    end
    if (rv !== value_q[0]) begin
      $display("%0t: read_value expected %h actual %h", $time, value_q[0], rv);
      errors++;
    end
    void'(status_q.pop_front());
    void'(value_q.pop_front());
  endfunction
endclass

[dv/two_table_cuckoo_hash_store_unit_test.sv]
module two_table_cuckoo_hash_store_unit_test import ttchs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   keys_used[$];

  ttchs_in_if  in_ch();
  ttchs_out_if out_ch();
  ttchs_store_scoreboard store_model = new();

  two_table_cuckoo_hash_store_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  task automatic send_command(logic [1:0] cmd, logic [31:0] k, logic [31:0] v);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.key <= k;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    store_model.note_command(cmd, k, v);
    @(negedge clk);
  endtask

  task automatic pause_input(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    if (keys_used.size() > 0 && $urandom_range(0, 3) != 0)
      return keys_used[$urandom_range(0, keys_used.size() - 1)];
    k = $urandom_range(0, 2) == 0 ? $urandom_range(0, 1500) : $urandom;
    keys_used = {keys_used, int'(k)};
    return k;
  endfunction

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready)
      store_model.check_result(out_ch.status, out_ch.read_value);
  end

  initial begin
    int cyc;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 1000 && cyc < 1400) out_ch.ready <= 1'b0;
      else if ((cyc / 64) % 3 == 0) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    logic [1:0] cmd;
    logic [31:0] k;
    int burst;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_SEARCH;
    in_ch.key = '0;
    in_ch.value = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_command(CMD_SEARCH, 32'h0, 32'h0);
    send_command(CMD_INSERT, 32'h0, 32'hffffffff);
    send_command(CMD_INSERT, 32'hffffffff, 32'h80000000);
    send_command(CMD_INSERT, 32'h80000000, 32'h7fffffff);
    send_command(CMD_INSERT, 32'h7fffffff, 32'h0);
    send_command(CMD_SEARCH, 32'h0, 32'h0);
    send_command(CMD_SEARCH, 32'hffffffff, 32'h0);
    send_command(CMD_SEARCH, 32'h80000000, 32'h0);
    send_command(CMD_SEARCH, 32'h7fffffff, 32'h0);
    send_command(CMD_INSERT, 32'h0, 32'h12345678);
    send_command(CMD_SEARCH, 32'h0, 32'h0);
    send_command(CMD_REMOVE, 32'h0, 32'h0);
    send_command(CMD_REMOVE, 32'h0, 32'h0);
    send_command(CMD_SEARCH, 32'h0, 32'h0);
    send_command(CMD_NOP, 32'hffffffff, 32'hffffffff);
    send_command(CMD_SEARCH, 32'hffffffff, 32'h0);
    for (int i = 0; i < 12; i++) send_command(CMD_INSERT, 32'h1000 + i, $urandom);
    for (int n = 0; n < 900; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++, n++) begin
        k = pick_key();
        case ($urandom_range(0, 9))
          0, 1, 2: cmd = CMD_SEARCH;
          3, 4, 5, 6, 7: cmd = CMD_INSERT;
          8: cmd = CMD_REMOVE;
          default: cmd = CMD_NOP;
        endcase
        send_command(cmd, k, $urandom);
      end
      if ($urandom_range(0, 1)) pause_input($urandom_range(1, 15));
    end
    for (int i = 0; i < 600; i++) send_command(CMD_INSERT, $urandom, $urandom);
    in_ch.valid <= 1'b0;
    while (store_model.status_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (store_model.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

[files.f]
rtl/ttchs_pkg.sv
rtl/ttchs_if.sv
rtl/ttchs_ram.sv
rtl/ttchs_hash.sv
rtl/ttchs_dp.sv
rtl/ttchs_ctrl.sv
rtl/two_table_cuckoo_hash_store_unit.sv
dv/ttchs_store_scoreboard.sv
dv/two_table_cuckoo_hash_store_unit_test.sv
